/* rtl/core/siku_pkg.sv */
`timescale 1ns / 1ps
// shared constants, widths and the arctangent table of the swerve kinematics unit
package siku_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int NUM_WHEELS       = 4;
  localparam int FW               = 16;  // width of command and register fields
  localparam int XW               = 25;  // wheel vector component, signed
  localparam int RADW             = 50;  // squared magnitude, padded to even
  localparam int ROOTW            = RADW / 2;
  localparam int ZW               = 30;  // angle accumulator, 2^-20 degree
  localparam int AW               = 16;  // wrapped angle, 1/64 degree
  localparam int OAW              = 23;  // unwrapped angle
  localparam int TCW              = 8;   // turn counter
  localparam int ATAN_W           = 27;

  localparam logic signed [ZW-1:0] Z_HALF_TURN = 30'sd188743680;
  localparam logic signed [ZW-1:0] ANG_MAX     = 30'sd11520;
  localparam logic signed [ZW-1:0] ANG_MIN     = -30'sd11520;

  // atan(2^-i) in 2^-20 degree
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 27'd47185920;
      5'd1:  v = 27'd27855475;
      5'd2:  v = 27'd14718068;
      5'd3:  v = 27'd7471121;
      5'd4:  v = 27'd3750058;
      5'd5:  v = 27'd1876857;
      5'd6:  v = 27'd938658;
      5'd7:  v = 27'd469357;
      5'd8:  v = 27'd234682;
      5'd9:  v = 27'd117342;
      5'd10: v = 27'd58671;
      5'd11: v = 27'd29335;
      5'd12: v = 27'd14668;
      5'd13: v = 27'd7334;
      5'd14: v = 27'd3667;
      5'd15: v = 27'd1833;
      5'd16: v = 27'd917;
      5'd17: v = 27'd458;
      5'd18: v = 27'd229;
      5'd19: v = 27'd115;
      5'd20: v = 27'd57;
      5'd21: v = 27'd29;
      5'd22: v = 27'd14;
      5'd23: v = 27'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/siku_sqrt.sv */
`timescale 1ns / 1ps
// digit-serial integer square root, two radicand bits per cycle, saturated result
module siku_sqrt import siku_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [RADW-1:0] rad_in,
  output logic            busy,
  output logic [FW-1:0]   speed
);

  localparam int NIT = RADW / 2;
  localparam int CNW = $clog2(NIT + 1);

  logic [RADW-1:0]  rad;
  logic [ROOTW:0]   rem;
  logic [ROOTW-1:0] root;
  logic [CNW-1:0]   cnt;
  logic [ROOTW+2:0] r2;
  logic [ROOTW+2:0] trial;
  logic [ROOTW+2:0] diff;

  always_comb begin
    r2    = {rem, rad[RADW-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    diff  = r2 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNW'(NIT);
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RADW-3:0], 2'b00};
      if (r2 >= trial) begin
        rem  <= diff[ROOTW:0];
        root <= {root[ROOTW-2:0], 1'b1};
      end else begin
        rem  <= r2[ROOTW:0];
        root <= {root[ROOTW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign speed = (|root[ROOTW-1:FW]) ? {FW{1'b1}} : root[FW-1:0];

endmodule

/* rtl/core/siku_cordic.sv */
`timescale 1ns / 1ps
// iterative vectoring cordic, one micro-rotation per cycle, gives -atan2(x, y)
module siku_cordic import siku_pkg::*; #(
  parameter int Steps = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [XW-1:0] xin,
  input  logic signed [XW-1:0] yin,
  output logic                 busy,
  output logic signed [AW-1:0] angle
);

  localparam int CW = XW + 19;
  localparam int IW = $clog2(Steps);

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] shx;
  logic signed [CW-1:0] shy;
  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  logic signed [ZW-1:0] z;
  logic signed [ZW-1:0] zt;
  logic signed [ZW-1:0] zr;
  logic [IW-1:0]        idx;

  always_comb begin
    xe  = {{(CW-XW-16){xin[XW-1]}}, xin, 16'h0000};
    ye  = {{(CW-XW-16){yin[XW-1]}}, yin, 16'h0000};
    shx = cy >>> idx;
    shy = cx >>> idx;
    zt  = $signed({{(ZW-ATAN_W){1'b0}}, atan_entry(5'(idx))});
    zr  = (-z + 30'sd8192) >>> 14;
    if (zr > ANG_MAX) begin
      angle = AW'(ANG_MAX);
    end else if (zr < ANG_MIN) begin
      angle = AW'(ANG_MIN);
    end else begin
      angle = zr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
      if (yin[XW-1]) begin
        // left half plane: fold over and preload a half turn
        cx <= -ye;
        cy <= -xe;
        z  <= xin[XW-1] ? -Z_HALF_TURN : Z_HALF_TURN;
      end else begin
        cx <= ye;
        cy <= xe;
        z  <= '0;
      end
    end else if (busy) begin
      if (!cy[CW-1]) begin
        cx <= cx + shx;
        cy <= cy - shy;
        z  <= z + zt;
      end else begin
        cx <= cx - shx;
        cy <= cy + shy;
        z  <= z - zt;
      end
      idx <= idx + 1'b1;
      if (idx == IW'(Steps - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/swerve_inverse_kinematics_unwrap_unit.sv */
`timescale 1ns / 1ps
// swerve inverse kinematics top: sequencer, serial multiplier and angle unwrap
// one command in work at a time, in_stall held meanwhile; the shared cordic and
// square root serve the four wheels in turn
// the next command is taken while a finished word still waits at the output
// sync reset restores half_track and half_base to 640 and clears prev and turn
module swerve_inverse_kinematics_unwrap_unit import siku_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [FW-1:0]         cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [FW-1:0]  vel_x,
  input  logic signed [FW-1:0]  vel_y,
  input  logic signed [FW-1:0]  yaw_rate,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FW-1:0]         speed_front_left,
  output logic [FW-1:0]         speed_front_right,
  output logic [FW-1:0]         speed_rear_right,
  output logic [FW-1:0]         speed_rear_left,
  output logic signed [OAW-1:0] angle_front_left,
  output logic signed [OAW-1:0] angle_front_right,
  output logic signed [OAW-1:0] angle_rear_right,
  output logic signed [OAW-1:0] angle_rear_left
);

  localparam logic [0:0] CFG_HALF_TRACK = 1'b0;
  localparam logic [0:0] CFG_HALF_BASE  = 1'b1;
  localparam int PW = 2 * FW + 1;
  localparam int WIW = $clog2(NUM_WHEELS);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_RND, S_SQX, S_SQY, S_START, S_RUN, S_UNW
  } state_t;

  state_t state;
  logic [FW-1:0]         half_track;
  logic [FW-1:0]         half_base;
  logic [FW-1:0]         hts;
  logic [FW-1:0]         hbs;
  logic [3:0]            mcnt;
  logic signed [PW-1:0]  mcand;
  logic signed [PW-1:0]  acc_t;
  logic signed [PW-1:0]  acc_b;
  logic signed [PW-1:0]  rnd_t;
  logic signed [PW-1:0]  rnd_b;
  logic signed [FW-1:0]  vx;
  logic signed [FW-1:0]  vy;
  logic signed [XW-1:0]  t;
  logic signed [XW-1:0]  b;
  logic [WIW-1:0]        wheel;
  logic signed [XW:0]    xsum;
  logic signed [XW:0]    ysum;
  logic signed [XW-1:0]  xw;
  logic signed [XW-1:0]  yw;
  logic signed [XW-1:0]  mop;
  logic signed [RADW-1:0] prod;
  logic [RADW-1:0]       sqx;
  logic [RADW-1:0]       rad;
  logic                  zero;
  logic                  sq_busy;
  logic                  co_busy;
  logic [FW-1:0]         sq_speed;
  logic signed [AW-1:0]  co_angle;
  logic signed [AW-1:0]  ang;
  logic signed [AW:0]    delta;
  logic signed [TCW-1:0] turn_next;
  logic signed [23:0]    total;
  logic signed [AW-1:0]  prev [NUM_WHEELS];
  logic signed [TCW-1:0] turn [NUM_WHEELS];
  logic [FW-1:0]         spd_w [NUM_WHEELS];
  logic signed [OAW-1:0] ang_w [NUM_WHEELS];

  siku_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_START),
    .rad_in (rad),
    .busy   (sq_busy),
    .speed  (sq_speed)
  );

  siku_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .xin   (xw),
    .yin   (yw),
    .busy  (co_busy),
    .angle (co_angle)
  );

  always_comb begin
    // wheel layout: front wheels subtract b, left wheels subtract t
    if (wheel == WIW'(0) || wheel == WIW'(3)) begin
      xsum = (XW+1)'(vx) - (XW+1)'(t);
    end else begin
      xsum = (XW+1)'(vx) + (XW+1)'(t);
    end
    if (wheel == WIW'(0) || wheel == WIW'(1)) begin
      ysum = (XW+1)'(vy) - (XW+1)'(b);
    end else begin
      ysum = (XW+1)'(vy) + (XW+1)'(b);
    end
    xw    = xsum[XW-1:0];
    yw    = ysum[XW-1:0];
    mop   = (state == S_SQX) ? xw : yw;
    prod  = mop * mop;
    rnd_t = (acc_t + PW'(128)) >>> 8;
    rnd_b = (acc_b + PW'(128)) >>> 8;
    ang   = zero ? '0 : co_angle;
    delta = (AW+1)'(ang) - (AW+1)'(prev[wheel]);
    turn_next = turn[wheel];
    if (delta <= -(AW+1)'(11520)) begin
      if (turn[wheel] != TCW'(127)) begin
        turn_next = turn[wheel] + 1'b1;
      end
    end else if (delta >= (AW+1)'(11520)) begin
      if (turn[wheel] != TCW'(128)) begin
        turn_next = turn[wheel] - 1'b1;
      end
    end
    total = 24'(ang) + 24'(turn_next) * 24'sd23040;
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      half_track <= 16'd640;
      half_base  <= 16'd640;
      wheel      <= '0;
      mcnt       <= '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        prev[i] <= '0;
        turn[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HALF_TRACK: half_track <= cfg_data;
          CFG_HALF_BASE:  half_base  <= cfg_data;
          default: ;
        endcase
      end
      // the last wheel loads a new word itself when the output frees up
      if (out_valid && !out_stall &&
          !(state == S_UNW && wheel == WIW'(NUM_WHEELS - 1))) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            vx    <= vel_x;
            vy    <= vel_y;
            mcand <= PW'(yaw_rate);
            hts   <= half_track;
            hbs   <= half_base;
            acc_t <= '0;
            acc_b <= '0;
            mcnt  <= '0;
            wheel <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // shift-add over the spacing bits, both products at once
          if (hts[0]) acc_t <= acc_t + mcand;
          if (hbs[0]) acc_b <= acc_b + mcand;
          hts   <= hts >> 1;
          hbs   <= hbs >> 1;
          mcand <= mcand <<< 1;
          mcnt  <= mcnt + 1'b1;
          if (mcnt == 4'd15) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          t     <= rnd_t[XW-1:0];
          b     <= rnd_b[XW-1:0];
          state <= S_SQX;
        end
        S_SQX: begin
          sqx   <= prod;
          state <= S_SQY;
        end
        S_SQY: begin
          rad   <= sqx + prod;
          zero  <= (xw == '0) && (yw == '0);
          state <= S_START;
        end
        S_START: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (!sq_busy && !co_busy) begin
            state <= S_UNW;
          end
        end
        S_UNW: begin
          if (wheel != WIW'(NUM_WHEELS - 1)) begin
            prev[wheel]  <= ang;
            turn[wheel]  <= turn_next;
            spd_w[wheel] <= sq_speed;
            ang_w[wheel] <= total[OAW-1:0];
            wheel        <= wheel + 1'b1;
            state        <= S_SQX;
          end else if (!out_valid || !out_stall) begin
            prev[wheel]       <= ang;
            turn[wheel]       <= turn_next;
            speed_front_left  <= spd_w[0];
            speed_front_right <= spd_w[1];
            speed_rear_right  <= spd_w[2];
            speed_rear_left   <= sq_speed;
            angle_front_left  <= ang_w[0];
            angle_front_right <= ang_w[1];
            angle_rear_right  <= ang_w[2];
            angle_rear_left   <= total[OAW-1:0];
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/swerve_inverse_kinematics_unwrap_unit_tb.sv */
`timescale 1ns / 1ps
// testbench of the swerve kinematics unit: directed and random commands checked against a predictor
module swerve_inverse_kinematics_unwrap_unit_tb;
  import siku_pkg::*;

  localparam int HALF_TURN = 11520;
  localparam int FULL_TURN = 23040;
  localparam int LATENCY   = 138;
  localparam logic [0:0] REG_HALF_TRACK = 1'b0;
  localparam logic [0:0] REG_HALF_BASE  = 1'b1;

  typedef struct packed {
    logic [3:0][15:0] speed;
    logic [3:0][22:0] angle;
  } wheel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [FW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [FW-1:0] vel_x = '0, vel_y = '0, yaw_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FW-1:0] speed_front_left, speed_front_right, speed_rear_right, speed_rear_left;
  logic signed [OAW-1:0] angle_front_left, angle_front_right, angle_rear_right,
                         angle_rear_left;

  swerve_inverse_kinematics_unwrap_unit i_dut (.*);

  initial forever #1 clk = ~clk;

  // predictor state
  longint track_q88 = 640, base_q88 = 640;
  longint last_angle [4];
  longint turns [4];
  wheel_word_t expected_words [$];
  int mismatches = 0;
  bit hold_off = 1'b0;
  bit long_gaps = 1'b1;

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint steer_of(longint x, longint y);
    longint cx, cy, z, nx, ny, r;
    z = 0;
    if (x == 0 && y == 0) return 0;
    cx = y * 65536;
    cy = x * 65536;
    if (cx < 0) begin
      z = (cy >= 0) ? 180 * 1048576 : -180 * 1048576;
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
      if (cy >= 0) begin
        nx = cx + floor_shr(cy, i);
        ny = cy - floor_shr(cx, i);
        z += longint'(atan_entry(5'(i)));
      end else begin
        nx = cx - floor_shr(cy, i);
        ny = cy + floor_shr(cx, i);
        z -= longint'(atan_entry(5'(i)));
      end
      cx = nx;
      cy = ny;
    end
    r = floor_shr(-z + 8192, 14);
    if (r > HALF_TURN) r = HALF_TURN;
    if (r < -HALF_TURN) r = -HALF_TURN;
    return r;
  endfunction

  function automatic wheel_word_t predict_wheels(logic signed [15:0] vx, logic signed [15:0] vy,
                                                 logic signed [15:0] vw);
    wheel_word_t w;
    longint t, b, x, y, mag, ang, delta;
    t = floor_shr(longint'(vw) * track_q88 + 128, 8);
    b = floor_shr(longint'(vw) * base_q88 + 128, 8);
    for (int i = 0; i < 4; i++) begin
      x = longint'(vx) + ((i == 0 || i == 3) ? -t : t);
      y = longint'(vy) + ((i < 2) ? -b : b);
      mag = int_sqrt(longint'(x * x + y * y));
      ang = steer_of(x, y);
      delta = ang - last_angle[i];
      if (delta <= -HALF_TURN) begin
        if (turns[i] < 127) turns[i]++;
      end else if (delta >= HALF_TURN) begin
        if (turns[i] > -128) turns[i]--;
      end
      last_angle[i] = ang;
      w.speed[i] = (mag > 65535) ? 16'hFFFF : 16'(mag);
      w.angle[i] = 23'(ang + FULL_TURN * turns[i]);
    end
    return w;
  endfunction

  function automatic int gap_len();
    if (!long_gaps) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  // valid stays up between words sent back to back
  task automatic send_command(logic signed [15:0] vx, logic signed [15:0] vy,
                              logic signed [15:0] vw);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    vel_x <= vx;
    vel_y <= vy;
    yaw_rate <= vw;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(predict_wheels(vx, vy, vw));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_HALF_TRACK) track_q88 = val;
    else base_q88 = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    wheel_word_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.speed = {speed_rear_left, speed_rear_right, speed_front_right, speed_front_left};
      got.angle = {angle_rear_left, angle_rear_right, angle_front_right, angle_front_left};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.speed[i] !== want.speed[i] || got.angle[i] !== want.angle[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("wheel %0d: expected speed %0d angle %0d, got speed %0d angle %0d",
                       i, want.speed[i], $signed(want.angle[i]), got.speed[i],
                       $signed(got.angle[i]));
          end
        end
      end
    end
  end

  // receiver stalls; a long hold-off when asked
  initial begin
    int n;
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        for (n = 0; n < 2000; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= long_gaps ? (gap_len() > 2) : 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic test_extremes();
    logic signed [15:0] edges [6] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001,
                                      16'shFFFF, 16'sh5555};
    send_command(0, 0, 0);
    for (int i = 0; i < 6; i++) send_command(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_command(16'sh8000, 16'sh8000, 16'sh8000);
    send_command(16'sh2AAA, 16'shD555, 16'sh0000);
  endtask

  // angle swings across the rear axis to wind and unwind the turn counters
  task automatic test_turn_wrap(int steps, bit forward);
    for (int i = 0; i < steps; i++) begin
      send_command(forward ? 16'sd100 : -16'sd100, -16'sd1000, 0);
      send_command(forward ? -16'sd100 : 16'sd100, -16'sd1000, 0);
    end
  endtask

  task automatic test_config_sweep();
    logic [15:0] vals [4] = '{16'h0000, 16'hFFFF, 16'h0100, 16'hAAAA};
    for (int k = 0; k < 4; k++) begin
      drain();
      write_reg(REG_HALF_TRACK, vals[k]);
      write_reg(REG_HALF_BASE, vals[3 - k]);
      for (int i = 0; i < 8; i++)
        send_command(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++)
      send_command(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_random(int count);
    logic signed [15:0] vx, vy, vw;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        drain();
        write_reg(REG_HALF_TRACK, 16'($urandom_range(0, 2000)));
        write_reg(REG_HALF_BASE, 16'($urandom));
        long_gaps = (i % 400 == 0);
      end
      case ($urandom_range(0, 3))
        0: begin
          vx = 16'($urandom);
          vy = 16'($urandom);
          vw = 16'($urandom);
        end
        1: begin
          vx = 16'($signed($urandom_range(0, 400)) - 200);
          vy = 16'($signed($urandom_range(0, 400)) - 200);
          vw = 16'($signed($urandom_range(0, 40)) - 20);
        end
        2: begin
          // near the rear axis so the angle flips sign
          vx = 16'($signed($urandom_range(0, 60)) - 30);
          vy = -16'($urandom_range(100, 30000));
          vw = 0;
        end
        default: begin
          vx = 16'($urandom);
          vy = 16'($urandom);
          vw = 0;
        end
      endcase
      send_command(vx, vy, vw);
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      last_angle[i] = 0;
      turns[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_turn_wrap(140, 1'b1);
    test_turn_wrap(140, 1'b0);
    test_config_sweep();
    test_backpressure();
    test_random(640);
    long_gaps = 1'b0;
    drain();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("swerve_inverse_kinematics_unwrap_unit_tb: clean");
    end else begin
      $display("swerve_inverse_kinematics_unwrap_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("swerve_inverse_kinematics_unwrap_unit_tb: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/siku_pkg.sv
rtl/core/siku_sqrt.sv
rtl/core/siku_cordic.sv
rtl/core/swerve_inverse_kinematics_unwrap_unit.sv
tb/sv/swerve_inverse_kinematics_unwrap_unit_tb.sv
